@@ src/gbca_pkg.sv @@
package gbca_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SCALE     = 1000;
    localparam int KMUL_W    = 14;
    localparam int PROD_W    = 47;
    localparam int LIMIT_W   = 49;

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMBALANCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_EDGES  = 2'd2;

    typedef struct packed {
        logic sav_we;
        logic load_we;
        logic clear_sav;
        logic clear_load;
    } store_ctrl_t;

    function automatic logic [DATA_W-1:0] sat32(input logic [DATA_W:0] v);
        return v[DATA_W] ? {DATA_W{1'b1}} : v[DATA_W-1:0];
    endfunction

endpackage

@@ src/gbca_store.sv @@
module gbca_store #(
    parameter int NUM_CORES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gbca_pkg::store_ctrl_t        ctrl,
    input  logic [$clog2(NUM_CORES)-1:0] rd_addr,
    input  logic [$clog2(NUM_CORES)-1:0] wr_addr,
    input  logic [gbca_pkg::DATA_W-1:0]  wdata,
    output logic [gbca_pkg::DATA_W-1:0]  sav_rdata,
    output logic [gbca_pkg::DATA_W-1:0]  load_rdata
);
    import gbca_pkg::*;

    logic [DATA_W-1:0]    sav_mem  [NUM_CORES];
    logic [DATA_W-1:0]    load_mem [NUM_CORES];
    logic [DATA_W-1:0]    sav_rd_reg;
    logic [DATA_W-1:0]    load_rd_reg;
    logic [NUM_CORES-1:0] sav_valid_reg;
    logic [NUM_CORES-1:0] load_valid_reg;
    logic                 sav_vrd_reg;
    logic                 load_vrd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.sav_we)
        begin
            sav_mem[wr_addr] <= wdata;
        end
        if (ctrl.load_we)
        begin
            load_mem[wr_addr] <= wdata;
        end
        sav_rd_reg  <= sav_mem[rd_addr];
        load_rd_reg <= load_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sav_valid_reg  <= '0;
            load_valid_reg <= '0;
            sav_vrd_reg    <= 1'b0;
            load_vrd_reg   <= 1'b0;
        end
        else
        begin
            sav_vrd_reg  <= sav_valid_reg[rd_addr];
            load_vrd_reg <= load_valid_reg[rd_addr];
            if (ctrl.clear_sav)
            begin
                sav_valid_reg <= '0;
            end
            else if (ctrl.sav_we)
            begin
                sav_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.clear_load)
            begin
                load_valid_reg <= '0;
            end
            else if (ctrl.load_we)
            begin
                load_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign sav_rdata  = sav_vrd_reg  ? sav_rd_reg  : '0;
    assign load_rdata = load_vrd_reg ? load_rd_reg : '0;

endmodule

@@ src/gbca_seq.sv @@
module gbca_seq #(
    parameter int NUM_CORES    = 16,
    parameter int MAX_ACCESSES = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [3:0]                   item_core,
    input  logic                         is_read,
    input  logic [15:0]                  reader_count,
    input  logic [15:0]                  writer_count,
    input  logic                         last_access,
    input  logic [4:0]                   core_count,
    input  logic [15:0]                  imbalance_factor,
    input  logic [31:0]                  total_edges,
    output logic                         done,
    output logic [3:0]                   assigned_core,
    output logic                         no_fit,
    output gbca_pkg::store_ctrl_t        ctrl,
    output logic [$clog2(NUM_CORES)-1:0] rd_addr,
    output logic [$clog2(NUM_CORES)-1:0] wr_addr,
    output logic [gbca_pkg::DATA_W-1:0]  wdata,
    input  logic [gbca_pkg::DATA_W-1:0]  sav_rdata,
    input  logic [gbca_pkg::DATA_W-1:0]  load_rdata
);
    import gbca_pkg::*;

    localparam int CW    = $clog2(NUM_CORES);
    localparam int CNT_W = $clog2(MAX_ACCESSES + 1);
    localparam int EXT_W = 8;
    localparam int KMAX  = (NUM_CORES < 16) ? NUM_CORES : 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_SCAN,
        S_FIN
    } state_t;

    state_t               state_reg;
    logic [3:0]           core_reg;
    logic                 is_read_reg;
    logic [15:0]          readers_reg;
    logic [15:0]          writers_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [4:0]           k_reg;
    logic [KMUL_W-1:0]    km_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [4:0]           issue_cnt_reg;
    logic                 p1v_reg;
    logic [3:0]           p1_idx_reg;
    logic                 p2v_reg;
    logic [3:0]           p2_idx_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DATA_W-1:0]    p2_sav_reg;
    logic [DATA_W-1:0]    p2_load_reg;
    logic                 found_reg;
    logic [3:0]           best_idx_reg;
    logic [DATA_W-1:0]    best_sav_reg;
    logic [DATA_W-1:0]    best_load_reg;
    logic                 done_reg;
    logic [3:0]           chosen_reg;
    logic                 no_fit_reg;

    logic [EXT_W-1:0]     core_ext;
    logic [EXT_W-1:0]     in_core_ext;
    logic [EXT_W-1:0]     issue_ext;
    logic [EXT_W-1:0]     best_ext;
    logic                 in_range;
    logic [17:0]          weight;
    logic [CNT_W-1:0]     count_next;
    logic [4:0]           k_raw;
    logic [4:0]           k_next;
    logic [16:0]          imb_sum;
    logic [DATA_W:0]      load_plus_n;
    logic                 fits;
    logic                 accept;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg != S_IDLE);
    assign core_ext    = EXT_W'(core_reg);
    assign in_core_ext = EXT_W'(item_core);
    assign issue_ext   = EXT_W'(issue_cnt_reg);
    assign best_ext    = EXT_W'(best_idx_reg);
    assign in_range    = core_ext < EXT_W'(NUM_CORES);
    assign weight      = is_read_reg ? (18'(writers_reg) + 18'd1)
                                     : (18'(readers_reg) + 18'(writers_reg) + 18'd1);
    assign count_next  = (count_reg < CNT_W'(MAX_ACCESSES)) ? (count_reg + CNT_W'(1))
                                                            : count_reg;
    assign k_raw       = (core_count == 5'd0) ? 5'd1 : core_count;
    assign k_next      = (k_raw > 5'(KMAX)) ? 5'(KMAX) : k_raw;
    assign imb_sum     = 17'(imbalance_factor) + 17'(SCALE);
    assign load_plus_n = (DATA_W+1)'(load_rdata) + (DATA_W+1)'(n_reg);
    assign fits        = LIMIT_W'(prod_reg) < limit_reg;

    always_comb
    begin
        ctrl    = '0;
        rd_addr = '0;
        wr_addr = '0;
        wdata   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr         = in_core_ext[CW-1:0];
                ctrl.clear_sav  = accept && kind;
                ctrl.clear_load = accept && kind;
            end
            S_ACC:
            begin
                ctrl.sav_we = in_range;
                wr_addr     = core_ext[CW-1:0];
                wdata       = sat32((DATA_W+1)'(sav_rdata) + (DATA_W+1)'(weight));
            end
            S_SCAN:
            begin
                rd_addr = issue_ext[CW-1:0];
            end
            S_FIN:
            begin
                ctrl.load_we   = found_reg;
                ctrl.clear_sav = 1'b1;
                wr_addr        = best_ext[CW-1:0];
                wdata          = sat32((DATA_W+1)'(best_load_reg) + (DATA_W+1)'(n_reg));
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            core_reg      <= '0;
            is_read_reg   <= 1'b0;
            readers_reg   <= '0;
            writers_reg   <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            n_reg         <= '0;
            k_reg         <= 5'd1;
            km_reg        <= '0;
            limit_reg     <= '0;
            issue_cnt_reg <= '0;
            p1v_reg       <= 1'b0;
            p1_idx_reg    <= '0;
            p2v_reg       <= 1'b0;
            p2_idx_reg    <= '0;
            prod_reg      <= '0;
            p2_sav_reg    <= '0;
            p2_load_reg   <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_sav_reg  <= '0;
            best_load_reg <= '0;
            done_reg      <= 1'b0;
            chosen_reg    <= '0;
            no_fit_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (kind)
                        begin
                            count_reg <= '0;
                        end
                        else
                        begin
                            core_reg    <= item_core;
                            is_read_reg <= is_read;
                            readers_reg <= reader_count;
                            writers_reg <= writer_count;
                            last_reg    <= last_access;
                            state_reg   <= S_ACC;
                        end
                    end
                end
                S_ACC:
                begin
                    if (last_reg)
                    begin
                        count_reg     <= '0;
                        n_reg         <= count_next;
                        k_reg         <= k_next;
                        km_reg        <= KMUL_W'(k_next * SCALE);
                        limit_reg     <= LIMIT_W'(imb_sum) * LIMIT_W'(total_edges);
                        issue_cnt_reg <= '0;
                        p1v_reg       <= 1'b0;
                        p2v_reg       <= 1'b0;
                        found_reg     <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        count_reg <= count_next;
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (issue_cnt_reg < k_reg)
                    begin
                        p1v_reg       <= 1'b1;
                        p1_idx_reg    <= issue_cnt_reg[3:0];
                        issue_cnt_reg <= issue_cnt_reg + 5'd1;
                    end
                    else
                    begin
                        p1v_reg <= 1'b0;
                    end
                    p2v_reg <= p1v_reg;
                    if (p1v_reg)
                    begin
                        prod_reg    <= PROD_W'(load_plus_n) * PROD_W'(km_reg);
                        p2_sav_reg  <= sav_rdata;
                        p2_load_reg <= load_rdata;
                        p2_idx_reg  <= p1_idx_reg;
                    end
                    if (p2v_reg && fits && (!found_reg || (p2_sav_reg > best_sav_reg)))
                    begin
                        found_reg     <= 1'b1;
                        best_idx_reg  <= p2_idx_reg;
                        best_sav_reg  <= p2_sav_reg;
                        best_load_reg <= p2_load_reg;
                    end
                    if ((issue_cnt_reg == k_reg) && !p1v_reg && !p2v_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg   <= 1'b1;
                    chosen_reg <= found_reg ? best_idx_reg : 4'd0;
                    no_fit_reg <= !found_reg;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign assigned_core = chosen_reg;
    assign no_fit        = no_fit_reg;

`ifndef SYNTHESIS
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("result strobe without a finished scan");

    a_no_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_fit) |-> (assigned_core == 4'd0))
        else $error("no_fit with nonzero core");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind) |=> (!busy && !done))
        else $error("clear transaction left the block busy");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((issue_cnt_reg <= k_reg) && (k_reg <= 5'(KMAX))))
        else $error("scan index beyond active cores");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.sav_we && ctrl.load_we))
        else $error("both stores written in one cycle");
`endif

endmodule

@@ src/greedy_balanced_core_assign.sv @@
// Greedy balanced core assignment.
// Input channel: one item is taken at a rising edge with start high and
// busy low. kind=0 is an access of the current transaction, kind=1 clears all
// core loads and savings and drops any unfinished transaction.
// An access is accepted and then does one read-modify-write on the savings
// memory. A last access adds a scan of the K active cores through one
// shared multiply/compare stage, one core per cycle through the read (p1) and
// product (p2) stages, plus a commit state. A clear leaves the block idle.
// Result channel: done pulses for exactly one cycle with assigned_core and
// no_fit, in the cycle after the commit; the receiver cannot stall it and the
// block never holds a result back.
// Configuration: cfg_write/cfg_index/cfg_data write the core count (0),
// imbalance_factor (1) or total_edges (2); write only while idle.
// Reset: registers return to 16 cores, imbalance 30, zero edges; all loads,
// savings and the access count read as zero; no clearing pass is needed.
module greedy_balanced_core_assign #(
    parameter int NUM_CORES    = 16,
    parameter int MAX_ACCESSES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [3:0]                     item_core,
    input  logic                           is_read,
    input  logic [15:0]                    reader_count,
    input  logic [15:0]                    writer_count,
    input  logic                           last_access,
    input  logic                           cfg_write,
    input  logic [gbca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbca_pkg::DATA_W-1:0]    cfg_data,
    output logic                           done,
    output logic [3:0]                     assigned_core,
    output logic                           no_fit
);
    import gbca_pkg::*;

    localparam int CW = $clog2(NUM_CORES);

    logic [4:0]        core_count_reg;
    logic [15:0]       imbalance_reg;
    logic [31:0]       total_edges_reg;
    store_ctrl_t       ctrl;
    logic [CW-1:0]     rd_addr;
    logic [CW-1:0]     wr_addr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] sav_rdata;
    logic [DATA_W-1:0] load_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_count_reg   <= 5'd16;
            imbalance_reg    <= 16'd30;
            total_edges_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CORE_COUNT:   core_count_reg   <= cfg_data[4:0];
                CFG_IMBALANCE:    imbalance_reg    <= cfg_data[15:0];
                CFG_TOTAL_EDGES:  total_edges_reg  <= cfg_data[31:0];
                default:
                begin
                    core_count_reg <= core_count_reg;
                end
            endcase
        end
    end

    gbca_seq #(
        .NUM_CORES    (NUM_CORES),
        .MAX_ACCESSES (MAX_ACCESSES)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .item_core        (item_core),
        .is_read          (is_read),
        .reader_count     (reader_count),
        .writer_count     (writer_count),
        .last_access      (last_access),
        .core_count       (core_count_reg),
        .imbalance_factor (imbalance_reg),
        .total_edges      (total_edges_reg),
        .done             (done),
        .assigned_core    (assigned_core),
        .no_fit           (no_fit),
        .ctrl             (ctrl),
        .rd_addr          (rd_addr),
        .wr_addr          (wr_addr),
        .wdata            (wdata),
        .sav_rdata        (sav_rdata),
        .load_rdata       (load_rdata)
    );

    gbca_store #(
        .NUM_CORES (NUM_CORES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wdata      (wdata),
        .sav_rdata  (sav_rdata),
        .load_rdata (load_rdata)
    );

endmodule

@@ sim/testbench.sv @@
module testbench;
    import gbca_pkg::*;

    localparam int NUM_CORES    = 16;
    localparam int MAX_ACCESSES = 256;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 1150;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam bit KIND_ACCESS = 1'b0;
    localparam bit KIND_CLEAR  = 1'b1;

    typedef struct {
        logic [3:0] core;
        logic       fail;
    } assignment_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 kind;
    logic [3:0]           item_core;
    logic                 is_read;
    logic [15:0]          reader_count;
    logic [15:0]          writer_count;
    logic                 last_access;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 done;
    logic [3:0]           assigned_core;
    logic                 no_fit;

    assignment_t expected_assignments[$];

    bit [31:0]   pred_savings [NUM_CORES];
    bit [31:0]   pred_load [NUM_CORES];
    int unsigned pred_access_n;
    bit [4:0]    cfg_clusters;
    bit [15:0]   cfg_imbalance;
    bit [31:0]   cfg_edges;

    int unsigned     errors;
    int unsigned     items_sent;
    longint unsigned cycles;
    bit              no_idle;

    greedy_balanced_core_assign i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .item_core     (item_core),
        .is_read       (is_read),
        .reader_count  (reader_count),
        .writer_count  (writer_count),
        .last_access   (last_access),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .assigned_core (assigned_core),
        .no_fit        (no_fit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [31:0] sat_add(bit [31:0] a, longint unsigned b);
        longint unsigned s;
        s = 64'(a) + b;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(s);
    endfunction

    function automatic void clear_pass_state();
        foreach (pred_savings[c])
        begin
            pred_savings[c] = '0;
            pred_load[c]    = '0;
        end
        pred_access_n = 0;
    endfunction

    function automatic void predict_assignment(bit k, bit [3:0] core, bit rd,
                                               bit [15:0] readers, bit [15:0] writers,
                                               bit last);
        longint unsigned weight;
        longint unsigned limit;
        longint unsigned need;
        int unsigned     k_act;
        int unsigned     best;
        bit              found;
        assignment_t     a;
        if (k == KIND_CLEAR)
        begin
            clear_pass_state();
            return;
        end
        weight = rd ? 64'd1 + 64'(writers) : 64'd1 + 64'(readers) + 64'(writers);
        if (core < NUM_CORES)
            pred_savings[core] = sat_add(pred_savings[core], weight);
        if (pred_access_n < MAX_ACCESSES)
            pred_access_n++;
        if (!last)
            return;
        k_act = (cfg_clusters == 0) ? 1 : cfg_clusters;
        if (k_act > NUM_CORES)
            k_act = NUM_CORES;
        if (k_act > 16)
            k_act = 16;
        limit = (64'd1000 + 64'(cfg_imbalance)) * 64'(cfg_edges);
        found = 1'b0;
        best  = 0;
        for (int c = 0; c < k_act; c++)
        begin
            need = (64'(pred_load[c]) + 64'(pred_access_n)) * 64'(k_act) * 64'd1000;
            if (need < limit && (!found || pred_savings[c] > pred_savings[best]))
            begin
                best  = c;
                found = 1'b1;
            end
        end
        if (found)
            pred_load[best] = sat_add(pred_load[best], pred_access_n);
        foreach (pred_savings[c])
            pred_savings[c] = '0;
        pred_access_n = 0;
        a.core = found ? 4'(best) : 4'd0;
        a.fail = !found;
        expected_assignments.insert(expected_assignments.size(), a);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [15:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 16'($urandom_range(0, 3));
        if (r < 55)
            return 16'hFFFF;
        if (r < 65)
            return 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic bit [3:0] pick_core(int k_eff);
        if ($urandom_range(0, 3) != 0)
            return 4'($urandom_range(0, k_eff - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // Caller is at a falling edge; returns at a falling edge.
    task automatic send_item(bit k, bit [3:0] core, bit rd, bit [15:0] readers,
                             bit [15:0] writers, bit last);
        int gap;
        kind         <= k;
        item_core    <= core;
        is_read      <= rd;
        reader_count <= readers;
        writer_count <= writers;
        last_access  <= last;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_assignment(k, core, rd, readers, writers, last);
        items_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_access(bit [3:0] core, bit rd, bit [15:0] readers,
                               bit [15:0] writers, bit last);
        send_item(KIND_ACCESS, core, rd, readers, writers, last);
    endtask

    task automatic send_clear();
        send_item(KIND_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    // Drop start, wait for every transaction to complete, then let the block go idle.
    task automatic settle();
        start <= 1'b0;
        while (expected_assignments.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_CORE_COUNT:   cfg_clusters  = data[4:0];
            CFG_IMBALANCE:    cfg_imbalance = data[15:0];
            CFG_TOTAL_EDGES:  cfg_edges     = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] k_data, logic [31:0] imb_data,
                             logic [31:0] edges_data);
        settle();
        write_cfg(CFG_CORE_COUNT, k_data);
        write_cfg(CFG_IMBALANCE, imb_data);
        write_cfg(CFG_TOTAL_EDGES, edges_data);
    endtask

    task automatic random_transaction(int len, int k_eff, bit broken);
        for (int i = 0; i < len; i++)
            send_access(pick_core(k_eff), 1'($urandom_range(0, 1)), pick_count(),
                        pick_count(), !broken && i == len - 1);
        if (broken)
            send_clear();
    endtask

    // total_edges resets to zero, so nothing fits; 16 cores and imbalance 30 put the
    // single-access threshold between total_edges values 15 and 16.
    task automatic test_reset_state();
        send_access(4'd3, 1'b1, 16'd0, 16'd0, 1'b1);
        settle();
        write_cfg(CFG_TOTAL_EDGES, 32'd15);
        send_access(4'd3, 1'b1, 16'd0, 16'd0, 1'b1);
        settle();
        write_cfg(CFG_TOTAL_EDGES, 32'd16);
        send_access(4'd3, 1'b1, 16'd0, 16'd0, 1'b1);
    endtask

    task automatic test_weights_and_ties();
        configure(32'd4, 32'd30, 32'd4000);
        send_access(4'd2, 1'b1, 16'hFFFF, 16'd0, 1'b0);
        send_access(4'd3, 1'b0, 16'd0, 16'd0, 1'b1);
        send_access(4'd1, 1'b1, 16'd0, 16'hFFFF, 1'b0);
        send_access(4'd0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_access(4'd1, 1'b1, 16'd0, 16'hFFFF, 1'b1);
        send_access(4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_access(4'd3, 1'b1, 16'd0, 16'd0, 1'b1);
    endtask

    task automatic test_clear();
        configure(32'd2, 32'd0, 32'd6);
        send_access(4'd0, 1'b1, 16'd0, 16'd5, 1'b0);
        send_access(4'd0, 1'b1, 16'd0, 16'd5, 1'b1);
        send_access(4'd0, 1'b1, 16'd0, 16'd5, 1'b1);
        send_clear();
        send_access(4'd0, 1'b0, 16'd1, 16'd1, 1'b0);
        send_access(4'd0, 1'b0, 16'd1, 16'd1, 1'b1);
        send_access(4'd1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_clear();
        send_access(4'd0, 1'b1, 16'd0, 16'd0, 1'b1);
        send_access(4'd0, 1'b1, 16'd0, 16'd0, 1'b0);
        send_access(4'd0, 1'b1, 16'd0, 16'd0, 1'b1);
    endtask

    task automatic test_no_fit();
        configure(32'd3, 32'd0, 32'd3);
        send_access(4'd1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_access(4'd1, 1'b1, 16'd0, 16'd0, 1'b1);
        settle();
        write_cfg(CFG_TOTAL_EDGES, 32'd4);
        send_access(4'd2, 1'b1, 16'd0, 16'd0, 1'b1);
    endtask

    task automatic test_core_count_limits();
        configure(32'hFFFF_FFE0, 32'hFFFF_0000, 32'd100000);
        send_access(4'd5, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_access(4'd0, 1'b1, 16'd0, 16'd0, 1'b1);
        configure(32'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_access(4'd14, 1'b1, 16'd0, 16'd7, 1'b1);
        settle();
        write_cfg(CFG_UNUSED, 32'($urandom()));
        send_access(4'd9, 1'b1, 16'd0, 16'd3, 1'b1);
    endtask

    // Saturate the access count in one transaction.
    task automatic test_saturation();
        configure(32'd2, 32'd0, 32'd514);
        no_idle = 1'b1;
        for (int i = 0; i < 300; i++)
            send_access(4'd0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_access(4'd1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_access(4'd0, 1'b1, 16'd0, 16'd0, 1'b1);
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int unsigned base;
        int          k_cfg;
        int          k_eff;
        int          imb;
        int          r;
        int          len;
        int unsigned phase_start;
        bit [31:0]   edges;
        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                k_cfg = 0;
            else if (r < 12)
                k_cfg = $urandom_range(17, 31);
            else if (r < 20)
                k_cfg = 16;
            else
                k_cfg = $urandom_range(1, 16);
            k_eff = (k_cfg == 0) ? 1 : ((k_cfg > 16) ? 16 : k_cfg);
            r = $urandom_range(0, 99);
            if (r < 15)
                imb = 0;
            else if (r < 25)
                imb = 65535;
            else if (r < 45)
                imb = 30;
            else
                imb = $urandom_range(0, 2000);
            r = $urandom_range(0, 99);
            if (r < 6)
                edges = 32'd0;
            else if (r < 12)
                edges = $urandom();
            else if (r < 18)
                edges = 32'hFFFF_FFFF;
            else
                edges = 32'(k_eff * $urandom_range(2, 40));
            configure({27'($urandom()), 5'(k_cfg)}, {16'($urandom()), 16'(imb)}, edges);
            if ($urandom_range(0, 1))
                send_clear();
            phase_start = items_sent;
            while (items_sent < phase_start + 120)
            begin
                if ($urandom_range(0, 99) < 15)
                    no_idle = ~no_idle;
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_clear();
                else
                begin
                    len = $urandom_range(0, 99);
                    if (len < 80)
                        len = $urandom_range(1, 4);
                    else if (len < 95)
                        len = $urandom_range(5, 12);
                    else
                        len = $urandom_range(13, 40);
                    random_transaction(len, k_eff, r < 8);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        assignment_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_assignments.size());
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n && done)
        begin
            if (expected_assignments.size() == 0)
            begin
                $display("%0t: unexpected result: assigned_core %0d no_fit %0b", $time,
                         assigned_core, no_fit);
                errors++;
            end
            else
            begin
                want = expected_assignments.pop_front();
                if (assigned_core !== want.core)
                begin
                    $display("%0t: assigned_core expected %0d actual %0d", $time,
                             want.core, assigned_core);
                    errors++;
                end
                if (no_fit !== want.fail)
                begin
                    $display("%0t: no_fit expected %0b actual %0b", $time,
                             want.fail, no_fit);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = 1'b0;
        item_core    = '0;
        is_read      = 1'b0;
        reader_count = '0;
        writer_count = '0;
        last_access  = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        items_sent   = 0;
        cycles       = 0;
        no_idle      = 1'b0;
        cfg_clusters  = 5'd16;
        cfg_imbalance = 16'd30;
        cfg_edges     = 32'd0;
        clear_pass_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_weights_and_ties();
        test_clear();
        test_no_fit();
        test_core_count_limits();
        test_saturation();
        test_random();
        settle();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ greedy_balanced_core_assign.f @@
src/gbca_pkg.sv
src/gbca_store.sv
src/gbca_seq.sv
src/greedy_balanced_core_assign.sv
sim/testbench.sv
